// ===== src/xsfb_pkg.sv =====
// ----------------------------------------------------------------------------
// xsfb_pkg
// Shared types and constants for the XOR sprite framebuffer.
// ----------------------------------------------------------------------------
package xsfb_pkg;

    // Screen geometry in pixels
    localparam int SCREEN_WIDTH  = 64;
    localparam int SCREEN_HEIGHT = 32;
    localparam int PIXEL_COUNT   = SCREEN_WIDTH * SCREEN_HEIGHT;

    // Store holds eight pixels per byte
    localparam int STORE_BYTES = PIXEL_COUNT / 8;
    localparam int STORE_AW    = $clog2(STORE_BYTES);

    // Largest sprite row (pos_y + row_offset) and linear start address width
    localparam int ROW_MAX = 255 + 15;
    localparam int BASE_W  = $clog2(ROW_MAX * SCREEN_WIDTH + 255 + 8 + 1);
    localparam int IDX_W   = BASE_W - 3;

    // Item kinds (tuser)
    localparam logic [1:0] KIND_DRAW  = 2'd0;
    localparam logic [1:0] KIND_CLEAR = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    // Stream payload widths
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 16;

endpackage

// ===== src/xsfb_ram.sv =====
// ----------------------------------------------------------------------------
// xsfb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module xsfb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/xor_sprite_framebuffer_top.sv =====
// ----------------------------------------------------------------------------
// xor_sprite_framebuffer_top
// One-bit 64x32 framebuffer with XOR sprite-row draw, clear and byte read.
// ----------------------------------------------------------------------------
// Each input transaction carries one item, and each item gives exactly one
// result transaction. A draw item XORs an 8-pixel sprite row (bit 7 leftmost)
// into linear pixel address (pos_y + row_offset) * 64 + pos_x + bit; a row
// running past the right edge spills into the next screen row, and pixels at
// or beyond the end of the screen are dropped. The collision bit reports
// whether any lit pixel was turned off in the current sprite so far; it is
// cleared after the row flagged by tlast, and that result carries tlast. A
// clear item blanks the screen (per-byte valid flags are reset, the RAM
// itself is not swept) and returns tlast. A read item returns one store byte.
// Rate: the block takes one item at a time. A draw runs a small sequencer that
// after a prep step walks the two store bytes a row can touch through the
// single RAM port with one read and one read-modify-write step each, then a
// finish and a done step; a byte with no set pixel or off the screen skips
// its write step. A read passes through a read, a read-data and a done step,
// and a clear or an unused kind goes straight to the done step. No clearing
// pass is needed after reset. The result sits in an output register, so the
// next input is taken as soon as the result is registered, even if the
// consumer stalls it; the following result then waits until that register
// is free.
// ----------------------------------------------------------------------------
module xor_sprite_framebuffer_top
    import xsfb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // pos_x[7:0], pos_y[15:8], row_offset[19:16], row_bits[27:20],
    // read_index[35:28], zero pad [39:36]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // kind[1:0]
    input  logic [1:0]            s_axis_tuser,
    // last_row
    input  logic                  s_axis_tlast,

    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // collision[0], pixel_byte[8:1], zero pad [15:9]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // sprite_done
    output logic                  m_axis_tlast
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_FETCH,
        S_MERGE,
        S_READ,
        S_RDATA,
        S_FIN,
        S_DONE
    } state_t;

    state_t state_reg, state_next;

    // Captured item fields
    logic [1:0]             kind_reg, kind_next;
    logic [7:0]             px_reg, px_next;
    logic [7:0]             py_reg, py_next;
    logic [3:0]             off_reg, off_next;
    logic [7:0]             bits_reg, bits_next;
    logic                   last_reg, last_next;

    // Draw sequencer
    logic [IDX_W-1:0]       byte_idx_reg, byte_idx_next;
    logic [15:0]            mask_reg, mask_next;
    logic                   step_reg, step_next;
    logic                   hit_acc_reg, hit_acc_next;

    // Per-byte valid flags; an invalid byte reads as zero
    logic [STORE_BYTES-1:0] vld_reg, vld_next;
    logic                   vld_q_reg;

    // Pending result and output register
    logic                   res_coll_reg, res_coll_next;
    logic                   res_done_reg, res_done_next;
    logic [7:0]             res_byte_reg, res_byte_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   out_coll_reg, out_coll_next;
    logic                   out_done_reg, out_done_next;
    logic [7:0]             out_byte_reg, out_byte_next;

    // RAM port
    logic                   ram_we;
    logic [7:0]             ram_wdata;
    logic [7:0]             ram_rdata;
    logic [STORE_AW-1:0]    ram_addr;

    // Datapath helpers
    logic [BASE_W-1:0]      row_sum;
    logic [BASE_W-1:0]      base_addr;
    logic [7:0]             cur_mask;
    logic [7:0]             old_byte;
    logic                   in_range;
    logic                   in_accept;

    assign ram_addr  = byte_idx_reg[STORE_AW-1:0];
    assign in_range  = (byte_idx_reg < IDX_W'(STORE_BYTES));
    assign cur_mask  = step_reg ? mask_reg[7:0] : mask_reg[15:8];
    assign old_byte  = vld_q_reg ? ram_rdata : 8'h00;
    assign row_sum   = BASE_W'(py_reg) + BASE_W'(off_reg);
    assign base_addr = row_sum * BASE_W'(SCREEN_WIDTH) + BASE_W'(px_reg);

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W - 9){1'b0}}, out_byte_reg, out_coll_reg};
    assign m_axis_tlast  = out_done_reg;

    xsfb_ram #(
        .WIDTH (8),
        .DEPTH (STORE_BYTES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_addr),
        .wdata (ram_wdata),
        .raddr (ram_addr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        off_next       = off_reg;
        bits_next      = bits_reg;
        last_next      = last_reg;
        byte_idx_next  = byte_idx_reg;
        mask_next      = mask_reg;
        step_next      = step_reg;
        hit_acc_next   = hit_acc_reg;
        vld_next       = vld_reg;
        res_coll_next  = res_coll_reg;
        res_done_next  = res_done_reg;
        res_byte_next  = res_byte_reg;
        out_valid_next = out_valid_reg;
        out_coll_next  = out_coll_reg;
        out_done_next  = out_done_reg;
        out_byte_next  = out_byte_reg;
        ram_we         = 1'b0;
        ram_wdata      = old_byte ^ cur_mask;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    kind_next     = s_axis_tuser;
                    px_next       = s_axis_tdata[7:0];
                    py_next       = s_axis_tdata[15:8];
                    off_next      = s_axis_tdata[19:16];
                    bits_next     = s_axis_tdata[27:20];
                    last_next     = s_axis_tlast;
                    byte_idx_next = IDX_W'(s_axis_tdata[35:28]);
                    res_coll_next = 1'b0;
                    res_done_next = 1'b0;
                    res_byte_next = 8'h00;
                    unique case (s_axis_tuser)
                        KIND_DRAW:  state_next = S_PREP;
                        KIND_READ:  state_next = S_READ;
                        KIND_CLEAR:
                        begin
                            vld_next      = '0;
                            res_done_next = 1'b1;
                            state_next    = S_DONE;
                        end
                        default:    state_next = S_DONE;
                    endcase
                end
            end

            S_PREP:
            begin
                byte_idx_next = base_addr[BASE_W-1:3];
                mask_next     = {bits_reg, 8'h00} >> base_addr[2:0];
                step_next     = 1'b0;
                state_next    = S_FETCH;
            end

            // RAM read of byte_idx_reg is issued here; skip empty or off-screen bytes
            S_FETCH:
            begin
                if (in_range && (cur_mask != 8'h00))
                begin
                    state_next = S_MERGE;
                end
                else if (step_reg)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    step_next     = 1'b1;
                    byte_idx_next = byte_idx_reg + IDX_W'(1);
                end
            end

            S_MERGE:
            begin
                ram_we = 1'b1;
                vld_next[ram_addr] = 1'b1;
                if ((old_byte & cur_mask) != 8'h00)
                begin
                    hit_acc_next = 1'b1;
                end
                if (step_reg)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    step_next     = 1'b1;
                    byte_idx_next = byte_idx_reg + IDX_W'(1);
                    state_next    = S_FETCH;
                end
            end

            S_FIN:
            begin
                res_coll_next = hit_acc_reg;
                res_done_next = last_reg;
                if (last_reg)
                begin
                    hit_acc_next = 1'b0;
                end
                state_next = S_DONE;
            end

            S_READ:
            begin
                state_next = S_RDATA;
            end

            S_RDATA:
            begin
                res_byte_next = in_range ? old_byte : 8'h00;
                state_next    = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_coll_next  = res_coll_reg;
                    out_done_next  = res_done_reg;
                    out_byte_next  = res_byte_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            kind_reg      <= KIND_DRAW;
            px_reg        <= '0;
            py_reg        <= '0;
            off_reg       <= '0;
            bits_reg      <= '0;
            last_reg      <= 1'b0;
            byte_idx_reg  <= '0;
            mask_reg      <= '0;
            step_reg      <= 1'b0;
            hit_acc_reg   <= 1'b0;
            vld_reg       <= '0;
            vld_q_reg     <= 1'b0;
            res_coll_reg  <= 1'b0;
            res_done_reg  <= 1'b0;
            res_byte_reg  <= '0;
            out_valid_reg <= 1'b0;
            out_coll_reg  <= 1'b0;
            out_done_reg  <= 1'b0;
            out_byte_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            px_reg        <= px_next;
            py_reg        <= py_next;
            off_reg       <= off_next;
            bits_reg      <= bits_next;
            last_reg      <= last_next;
            byte_idx_reg  <= byte_idx_next;
            mask_reg      <= mask_next;
            step_reg      <= step_next;
            hit_acc_reg   <= hit_acc_next;
            vld_reg       <= vld_next;
            // valid flag follows the RAM read latency
            vld_q_reg     <= vld_reg[ram_addr];
            res_coll_reg  <= res_coll_next;
            res_done_reg  <= res_done_next;
            res_byte_reg  <= res_byte_next;
            out_valid_reg <= out_valid_next;
            out_coll_reg  <= out_coll_next;
            out_done_reg  <= out_done_next;
            out_byte_reg  <= out_byte_next;
        end
    end

    // A read result never closes a sprite
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tdata[8:1] != 8'h00)) |-> !m_axis_tlast)
        else $error("read data on a sprite-closing transaction");

    // Collision and read data never share a result
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[0] && (m_axis_tdata[8:1] != 8'h00)))
        else $error("collision set on a read result");

    // Closing row of a sprite leaves the collision accumulator clear
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_FIN) && last_reg) |=> !hit_acc_reg)
        else $error("collision accumulator kept after last row");

    // Store writes happen only for on-screen bytes
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (in_range && (state_reg == S_MERGE)))
        else $error("store write outside merge step or off screen");

    // One item at a time: no acceptance right after an acceptance
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> !s_axis_tready)
        else $error("second item accepted while busy");

endmodule

// ===== verif/xsfb_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// xsfb_checker
// Watches both stream ports of the sprite framebuffer, predicts each result
// from its own copy of the screen and compares field by field.
// ----------------------------------------------------------------------------
module xsfb_checker
    import xsfb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  logic [1:0]            s_axis_tuser,
    input  logic                  s_axis_tlast,

    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  m_axis_tlast,

    output int                    mismatches,
    output int                    outstanding
);

    typedef struct packed {
        logic       collision;
        logic       sprite_done;
        logic [7:0] pixel_byte;
    } screen_result_t;

    logic [7:0]     screen_bytes [STORE_BYTES];
    logic           sprite_hit;
    screen_result_t expected_results [$];
    int             err_count;
    int             n_taken;
    int             n_returned;

    assign mismatches  = err_count;
    assign outstanding = n_taken - n_returned;

    // XOR one 8-pixel row; bit 7 is the leftmost pixel
    function automatic void xor_row(input int px, input int py, input int off,
                                    input logic [7:0] bits);
        int         base;
        int         addr;
        logic [7:0] mask;
        base = (py + off) * SCREEN_WIDTH + px;
        for (int j = 0; j < 8; j++) begin
            if (bits[7-j]) begin
                addr = base + j;
                if (addr < PIXEL_COUNT) begin
                    mask = 8'h80 >> addr[2:0];
                    if ((screen_bytes[addr[10:3]] & mask) != 0)
                        sprite_hit = 1'b1;
                    screen_bytes[addr[10:3]] ^= mask;
                end
            end
        end
    endfunction

    function automatic screen_result_t predict_item(input logic [1:0] kind,
                                                    input logic [IN_DATA_W-1:0] data,
                                                    input logic last);
        screen_result_t res;
        res = '0;
        case (kind)
            KIND_DRAW: begin
                xor_row(int'(data[7:0]), int'(data[15:8]), int'(data[19:16]),
                        data[27:20]);
                res.collision = sprite_hit;
                if (last) begin
                    res.sprite_done = 1'b1;
                    sprite_hit      = 1'b0;
                end
            end
            KIND_CLEAR: begin
                // collision state survives a clear
                foreach (screen_bytes[i])
                    screen_bytes[i] = 8'h00;
                res.sprite_done = 1'b1;
            end
            KIND_READ: begin
                if (data[35:28] < STORE_BYTES)
                    res.pixel_byte = screen_bytes[data[35:28]];
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic void report(input string what, input screen_result_t exp_r,
                                   input screen_result_t act_r);
        if (err_count < 10)
            $display("%0t: %s exp coll=%0b done=%0b byte=%02h got coll=%0b done=%0b byte=%02h",
                     $realtime, what, exp_r.collision, exp_r.sprite_done, exp_r.pixel_byte,
                     act_r.collision, act_r.sprite_done, act_r.pixel_byte);
        err_count++;
    endfunction

    always @(posedge clk) begin
        screen_result_t got;
        screen_result_t want;
        if (!rst_n) begin
            foreach (screen_bytes[i])
                screen_bytes[i] = 8'h00;
            sprite_hit = 1'b0;
            expected_results.delete();
            err_count  = 0;
            n_taken    <= 0;
            n_returned <= 0;
        end
        else begin
            // results first, so a transaction taken this edge is never matched early
            if (m_axis_tvalid && m_axis_tready) begin
                got.collision   = m_axis_tdata[0];
                got.pixel_byte  = m_axis_tdata[8:1];
                got.sprite_done = m_axis_tlast;
                n_returned <= n_returned + 1;
                if (expected_results.size() == 0) begin
                    report("result with nothing pending:", '0, got);
                end
                else begin
                    want = expected_results.pop_front();
                    if (got.collision !== want.collision
                        || got.sprite_done !== want.sprite_done
                        || got.pixel_byte !== want.pixel_byte)
                        report("result mismatch:", want, got);
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                expected_results.push_back(predict_item(s_axis_tuser, s_axis_tdata,
                                                        s_axis_tlast));
                n_taken <= n_taken + 1;
            end
        end
    end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the XOR sprite framebuffer: directed corner items,
// then random sprites, reads, clears and noise with random stalls both ways.
// ----------------------------------------------------------------------------
module tb_top
    import xsfb_pkg::*;
;

    // kind code the block must treat as a no-op
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam int ITEM_TARGET = 1750;
    // slowest run is roughly 1750 items, each with its busy time plus the longest gap and stall
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_CYCLES = 20;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;

    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [1:0]            s_axis_tuser = KIND_DRAW;
    logic                  s_axis_tlast = 1'b0;

    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;

    int                    mismatches;
    int                    outstanding;
    int                    items_sent = 0;
    int                    cycle_count = 0;
    bit                    send_calm = 1'b0;

    xor_sprite_framebuffer_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    xsfb_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Watchdog: a hung handshake ends the run here
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Mostly no gap, some short ones, a few long ones
    function automatic int idle_length(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Result side: random backpressure, with calm stretches of steady tready
    initial
    begin
        int  stall;
        bit  calm;
        int  span;
        stall = 0;
        calm  = 1'b0;
        span  = 0;
        forever
        begin
            @(posedge clk);
            if (span == 0)
            begin
                calm = ($urandom_range(0, 3) == 0);
                span = $urandom_range(100, 400);
            end
            span--;
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                stall--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if (!calm && $urandom_range(0, 3) == 0)
                    stall = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                        : $urandom_range(1, 3);
            end
        end
    end

    // One input transaction. Called at a clock edge; returns at the edge where
    // the transaction was accepted, tvalid still high so back-to-back items
    // never drop it within one time step.
    task automatic send_item(input logic [1:0] kind, input logic [7:0] px,
                             input logic [7:0] py, input logic [3:0] off,
                             input logic [7:0] bits, input logic last,
                             input logic [7:0] ridx);
        int gap;
        gap = idle_length(send_calm);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tdata  <= {4'b0000, ridx, bits, off, py, px};
        s_axis_tuser  <= kind;
        s_axis_tlast  <= last;
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        items_sent++;
        if (items_sent % 250 == 0)
            send_calm = ($urandom_range(0, 2) == 0);
    endtask

    // Hold off until every expected result has come back
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic send_draw(input logic [7:0] px, input logic [7:0] py,
                             input logic [3:0] off, input logic [7:0] bits,
                             input logic last);
        send_item(KIND_DRAW, px, py, off, bits, last, 8'($urandom));
    endtask

    task automatic send_read(input logic [7:0] ridx);
        send_item(KIND_READ, 8'($urandom), 8'($urandom), 4'($urandom), 8'($urandom),
                  1'($urandom), ridx);
    endtask

    // A well-formed sprite: rows 0..n-1, last row flagged, occasional reads
    // between rows. Now and then the position is taken from the full range.
    task automatic send_sprite();
        int         rows;
        bit         wild;
        logic [7:0] px;
        logic [7:0] py;
        rows = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 8);
        wild = ($urandom_range(0, 9) == 0);
        px   = wild ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 63));
        py   = wild ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 31));
        for (int r = 0; r < rows; r++)
        begin
            send_draw(px, py, 4'(r), 8'($urandom), r == rows - 1);
            if ($urandom_range(0, 9) == 0)
                send_read(8'($urandom));
        end
    endtask

    initial
    begin
        int pick;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed corners ----
        send_read(8'd0);                              // blank after reset
        send_draw(8'd0, 8'd0, 4'd0, 8'hFF, 1'b0);     // lights row 0, pixels 0..7
        send_draw(8'd0, 8'd0, 4'd0, 8'h81, 1'b1);     // erases lit pixels: collision
        send_read(8'd0);                              // 0x7E left
        send_draw(8'd60, 8'd0, 4'd0, 8'hFF, 1'b1);    // runs off the right edge
        send_read(8'd7);
        send_read(8'd8);                              // spill into screen row 1
        send_draw(8'd63, 8'd31, 4'd0, 8'hC0, 1'b1);   // last pixel lit, next skipped
        send_read(8'd255);
        send_draw(8'd255, 8'd255, 4'd15, 8'hFF, 1'b0);// whole row past the screen
        send_draw(8'd0, 8'd0, 4'd0, 8'h02, 1'b0);     // hits a lit pixel, sprite open
        send_item(KIND_CLEAR, 8'hFF, 8'hFF, 4'hF, 8'hFF, 1'b1, 8'hFF);
        send_draw(8'd5, 8'd3, 4'd2, 8'h00, 1'b1);     // collision kept across clear
        send_item(KIND_UNUSED, 8'hFF, 8'hFF, 4'hF, 8'hFF, 1'b1, 8'hFF);
        send_read(8'd255);
        send_draw(8'd10, 8'd31, 4'd1, 8'hFF, 1'b1);   // row 32 is off screen
        send_draw(8'd200, 8'd0, 4'd0, 8'hA5, 1'b1);   // x beyond width lands in row 3
        send_read(8'd25);
        send_draw(8'd7, 8'd15, 4'd15, 8'h3C, 1'b1);   // offset at its top value
        send_read(8'd240);
        send_read(8'd128);

        // ---- random mix ----
        while (items_sent < ITEM_TARGET)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 68)
                send_sprite();
            else if (pick < 88)
                repeat ($urandom_range(1, 4)) send_read(8'($urandom));
            else if (pick < 92)
                send_item(KIND_CLEAR, 8'($urandom), 8'($urandom), 4'($urandom),
                          8'($urandom), 1'($urandom), 8'($urandom));
            else if (pick < 95)
                send_item(KIND_UNUSED, 8'($urandom), 8'($urandom), 4'($urandom),
                          8'($urandom), 1'($urandom), 8'($urandom));
            else
                // broken sprite: any offset, last flag at random
                send_draw(8'($urandom), 8'($urandom), 4'($urandom), 8'($urandom),
                          1'($urandom_range(0, 1)));

            // sender holds off mid-run until the pipeline is empty, after every batch in a 20-item window past the half
            if (items_sent >= ITEM_TARGET / 2 && items_sent < ITEM_TARGET / 2 + 20)
            begin
                wait_drained();
                @(posedge clk);
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && outstanding == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== files.f =====
src/xsfb_pkg.sv
src/xsfb_ram.sv
src/xor_sprite_framebuffer_top.sv
verif/xsfb_checker.sv
verif/tb_top.sv
